// File: rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants for the great-circle distance block
// Fixed-point constants, arctangent table and helpers.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int LatW   = 31;
  localparam int LonW   = 32;
  localparam int RadW   = 24;
  localparam int DistW  = 30;
  localparam int CordicStagesDef = 24;

  // Internal angle/trig width (Q1.30 plus CORDIC growth headroom)
  localparam int AW = 36;

  localparam logic [RadW-1:0] RadiusRst = 24'd6372795;

  localparam logic signed [AW-1:0] Deg90    = 36'sd754974720;
  localparam logic signed [AW-1:0] Deg180   = 36'sd1509949440;
  localparam logic signed [AW-1:0] Deg360   = 36'sd3019898880;
  localparam logic [31:0]          DegToRad = 32'd2398762259;
  localparam logic signed [AW-1:0] OneQ30   = 36'sd1073741824;
  localparam logic signed [AW-1:0] GainQ30  = 36'sd652032874;
  localparam logic signed [AW-1:0] PiQ30    = 36'sd3373259426;
  localparam logic signed [AW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic [DistW-1:0]     OutMax   = {DistW{1'b1}};

  typedef logic signed [AW-1:0] ang_t;

  function automatic ang_t atan_at(input int i);
    ang_t r;
    r = '0;
    unique case (i)
      0: r = 36'sd843314856;
      1: r = 36'sd497837829;
      2: r = 36'sd263043836;
      3: r = 36'sd133525158;
      4: r = 36'sd67021686;
      5: r = 36'sd33543515;
      6: r = 36'sd16775850;
      7: r = 36'sd8388437;
      8: r = 36'sd4194282;
      9: r = 36'sd2097149;
      default: begin
        if (i <= 30) r = ang_t'(36'sd1 <<< (30 - i));
        else r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic ang_t sat_q30(input ang_t v);
    ang_t r;
    r = v;
    if (v > OneQ30) r = OneQ30;
    else if (v < -OneQ30) r = -OneQ30;
    return r;
  endfunction

  // Q1.30 product, rounded, floor shift
  function automatic ang_t qmul(input ang_t a, input ang_t b);
    logic signed [2*AW-1:0] p;
    p = 72'(a) * 72'(b) + (72'sd1 <<< 29);
    return ang_t'(p >>> 30);
  endfunction

endpackage

// File: rtl/gcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_if: valid/ready channel interfaces
// Input positions, output distance and radius configuration.
// ----------------------------------------------------------------------------
interface gcd_in_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [LatW-1:0] first_latitude;
  logic signed [LonW-1:0] first_longitude;
  logic signed [LatW-1:0] second_latitude;
  logic signed [LonW-1:0] second_longitude;
  modport source (output valid, first_latitude, first_longitude,
                  second_latitude, second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude,
                second_latitude, second_longitude, output ready);
endinterface

interface gcd_out_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  logic [DistW-1:0] distance_sixteenths;
  modport source (output valid, distance_sixteenths, input ready);
  modport sink (input valid, distance_sixteenths, output ready);
endinterface

interface gcd_cfg_if import gcd_pkg::*; ();
  logic valid;
  logic ready;
  logic [RadW-1:0] sphere_radius_m;
  modport source (output valid, sphere_radius_m, input ready);
  modport sink (input valid, sphere_radius_m, output ready);
endinterface

// File: rtl/great_circle_distance.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle; the whole datapath is one pipeline that
// advances on a shared enable, so a stalled output holds every stage.
// Reset (rst_n low, synchronous) clears all stage valid bits and loads the
// radius register with 6372795 m.
// ----------------------------------------------------------------------------
// great_circle_distance: pipelined spherical distance
// Rotation CORDICs for sines/cosines, products, a bit-serial-per-stage square
// root, a vectoring CORDIC for atan2 and a radius scaling stage.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input logic    clk,
  input logic    rst_n,
  gcd_in_if.sink   in_ch,
  gcd_out_if.source out_ch,
  gcd_cfg_if.sink  cfg_ch
);

  localparam int NS = CORDIC_STAGES;
  localparam int SQ = 32;        // square root steps, two bits of input each
  // stage map: 0 prep, 1 rad, 2..NS+1 sincos, then products, sqrt, atan2
  localparam int P0 = NS + 2;    // first product stage
  localparam int S0 = P0 + 3;    // sqrt start
  localparam int A0 = S0 + SQ;   // atan2 start
  localparam int D0 = A0 + NS + 1; // angle clamp, then distance multiply
  localparam int NST = D0 + 2;

  // shared enable: pipeline moves when the output slot is free or empty
  logic adv;
  logic [NST-1:0] v_r;
  assign adv = !v_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = v_r[NST-1];

  logic [RadW-1:0] radius_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RadiusRst;
    else if (cfg_ch.valid) radius_r <= cfg_ch.sphere_radius_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NST-2:0], in_ch.valid};
  end

  // ---- stage 0: clamp latitudes, wrap and fold longitude difference
  ang_t lat1_r, lat2_r, dl_r;
  logic flip_r;
  always_ff @(posedge clk) begin
    ang_t l1, l2, d;
    logic f;
    l1 = ang_t'(in_ch.first_latitude);
    l2 = ang_t'(in_ch.second_latitude);
    if (l1 > Deg90) l1 = Deg90; else if (l1 < -Deg90) l1 = -Deg90;
    if (l2 > Deg90) l2 = Deg90; else if (l2 < -Deg90) l2 = -Deg90;
    d = ang_t'(in_ch.first_longitude) - ang_t'(in_ch.second_longitude);
    if (d >= Deg180) d = d - Deg360;
    if (d < -Deg180) d = d + Deg360;
    f = 1'b0;
    if (d > Deg90) begin d = d - Deg180; f = 1'b1; end
    else if (d < -Deg90) begin d = d + Deg180; f = 1'b1; end
    if (adv) begin
      lat1_r <= l1; lat2_r <= l2; dl_r <= d; flip_r <= f;
    end
  end

  // ---- stage 1: degrees to radians (one multiply per angle)
  function automatic ang_t d2r(input ang_t d);
    logic [AW-1:0] m;
    logic [AW+32-1:0] p;
    m = d[AW-1] ? AW'(-d) : AW'(d);
    p = (AW+32)'(m) * (AW+32)'(DegToRad) + (AW+32)'(64'd1 << 29);
    return d[AW-1] ? -ang_t'(p >> 30) : ang_t'(p >> 30);
  endfunction

  ang_t z_r [3][NS+1];
  ang_t x_r [3][NS+1];
  ang_t y_r [3][NS+1];
  logic flp_r [NS+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      z_r[0][0] <= d2r(dl_r);
      z_r[1][0] <= d2r(lat1_r);
      z_r[2][0] <= d2r(lat2_r);
      flp_r[0] <= flip_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_seed
    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[k][0] <= GainQ30;
        y_r[k][0] <= '0;
      end
    end
  end

  // ---- rotation CORDICs, one iteration per stage, three lanes
  for (genvar i = 0; i < NS; i++) begin : g_rot
    for (genvar k = 0; k < 3; k++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!z_r[k][i][AW-1]) begin
            x_r[k][i+1] <= x_r[k][i] - (y_r[k][i] >>> i);
            y_r[k][i+1] <= y_r[k][i] + (x_r[k][i] >>> i);
            z_r[k][i+1] <= z_r[k][i] - atan_at(i);
          end else begin
            x_r[k][i+1] <= x_r[k][i] + (y_r[k][i] >>> i);
            y_r[k][i+1] <= y_r[k][i] - (x_r[k][i] >>> i);
            z_r[k][i+1] <= z_r[k][i] + atan_at(i);
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) flp_r[i+1] <= flp_r[i];
    end
  end

  ang_t sdl, cdl, sl1, cl1, sl2, cl2;
  always_comb begin
    sdl = sat_q30(y_r[0][NS]);
    cdl = sat_q30(x_r[0][NS]);
    if (flp_r[NS]) begin sdl = -sdl; cdl = -cdl; end
    sl1 = sat_q30(y_r[1][NS]); cl1 = sat_q30(x_r[1][NS]);
    sl2 = sat_q30(y_r[2][NS]); cl2 = sat_q30(x_r[2][NS]);
  end

  // ---- products: three stages, one multiply deep each
  ang_t pa_r, pb_r, pc_r, pd_r, n2_r, cdl_r;
  ang_t n1_r, den_r, n2b_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r <= qmul(cl1, sl2);
      pb_r <= qmul(sl1, cl2);
      pc_r <= qmul(sl1, sl2);
      pd_r <= qmul(cl1, cl2);
      n2_r <= qmul(cl2, sdl);
      cdl_r <= cdl;
      n1_r  <= pa_r - qmul(pb_r, cdl_r);
      den_r <= pc_r + qmul(pd_r, cdl_r);
      n2b_r <= n2_r;
    end
  end

  // squares
  logic [63:0] sum_r;
  ang_t den2_r;
  always_ff @(posedge clk) begin
    logic signed [2*AW-1:0] q1, q2;
    q1 = 72'(n1_r) * 72'(n1_r);
    q2 = 72'(n2b_r) * 72'(n2b_r);
    if (adv) begin
      sum_r <= 64'(q1) + 64'(q2);
      den2_r <= den_r;
    end
  end

  // ---- integer square root, one result bit per stage (bit = 4^(31-j))
  logic [63:0] sv_r [SQ+1];
  logic [63:0] sres_r [SQ+1];
  ang_t sden_r [SQ+1];
  always_comb begin
    sv_r[0] = sum_r;
    sres_r[0] = '0;
    sden_r[0] = den2_r;
  end
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'd1 << (62 - 2*j);
    always_ff @(posedge clk) begin
      if (adv) begin
        if (sv_r[j] >= sres_r[j] + Bit) begin
          sv_r[j+1]   <= sv_r[j] - (sres_r[j] + Bit);
          sres_r[j+1] <= (sres_r[j] >> 1) + Bit;
        end else begin
          sv_r[j+1]   <= sv_r[j];
          sres_r[j+1] <= sres_r[j] >> 1;
        end
        sden_r[j+1] <= sden_r[j];
      end
    end
  end

  // ---- atan2 prep: quadrant rotation and zero case
  ang_t ax_r [NS+1];
  ang_t ay_r [NS+1];
  ang_t az_r [NS+1];
  logic azero_r [NS+1];
  always_ff @(posedge clk) begin
    ang_t ny, nx;
    ny = ang_t'(sres_r[SQ]);
    nx = sden_r[SQ];
    if (adv) begin
      azero_r[0] <= (ny == '0) && (nx == '0);
      if (nx[AW-1]) begin
        ax_r[0] <= ny; ay_r[0] <= -nx; az_r[0] <= HalfPiQ30;
      end else begin
        ax_r[0] <= nx; ay_r[0] <= ny; az_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        if (ay_r[i] > 0) begin
          ax_r[i+1] <= ax_r[i] + (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] - (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] + atan_at(i);
        end else begin
          ax_r[i+1] <= ax_r[i] - (ay_r[i] >>> i);
          ay_r[i+1] <= ay_r[i] + (ax_r[i] >>> i);
          az_r[i+1] <= az_r[i] - atan_at(i);
        end
        azero_r[i+1] <= azero_r[i];
      end
    end
  end

  // ---- clamp angle, then scale by radius and round
  logic [31:0] ang_r;
  always_ff @(posedge clk) begin
    ang_t a;
    a = az_r[NS];
    if (azero_r[NS] || a[AW-1]) a = '0;
    if (a > PiQ30) a = PiQ30;
    if (adv) ang_r <= a[31:0];
  end

  logic [DistW-1:0] dist_r;
  always_ff @(posedge clk) begin
    logic [55:0] p;
    logic [29:0] d;
    p = 56'(ang_r) * 56'(radius_r) + 56'(64'd1 << 25);
    d = (p[55:26] > 30'(OutMax)) ? OutMax : p[55:26];
    if (adv) dist_r <= d;
  end
  assign out_ch.distance_sixteenths = dist_r;

endmodule

// File: rtl/gcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_checker: port-level checks on the distance block
// Input and output handshake and reset behavior.
// ----------------------------------------------------------------------------
module gcd_checker import gcd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [DistW-1:0] out_dist
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dist))
    else $error("result dropped under stall");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_dist(out_ch.distance_sixteenths)
);
